// ===== sv/m1vpf_pkg.sv =====
// Package for the MPEG-1 video picture framer: start code bytes, mode encodings, helpers.
`default_nettype none
package m1vpf_pkg;

    localparam logic [7:0] CODE_PIC      = 8'h00;
    localparam logic [7:0] CODE_SLICE_LO = 8'h01;
    localparam logic [7:0] CODE_SLICE_HI = 8'haf;
    localparam logic [7:0] CODE_USER     = 8'hb2;
    localparam logic [7:0] CODE_SEQ      = 8'hb3;
    localparam logic [7:0] CODE_EXT      = 8'hb5;
    localparam logic [7:0] CODE_SEQ_END  = 8'hb7;
    localparam logic [7:0] CODE_GOP      = 8'hb8;

    localparam logic [3:0] ASPECT_DEFAULT = 4'd1;
    localparam logic [3:0] ASPECT_MAX     = 4'd14;
    localparam logic [3:0] RATE_DEFAULT   = 4'd3;
    localparam logic [3:0] RATE_MAX       = 4'd8;

    localparam int unsigned DELAY_DEPTH = 3;
    localparam int unsigned CAPTURE_BYTES = 4;

    typedef enum logic [2:0] {
        MODE_CHECK = 3'b001,
        MODE_HUNT  = 3'b010,
        MODE_SYNC  = 3'b100
    } sync_mode_t;

    typedef enum logic [2:0] {
        CAP_NONE = 3'b001,
        CAP_SEQ  = 3'b010,
        CAP_GOP  = 3'b100
    } capture_kind_t;

    // start code byte that may legally open a stream
    function automatic logic valid_head(input logic [7:0] b);
        valid_head = (b == CODE_PIC) || (b == CODE_SEQ) || (b == CODE_GOP) ||
                     (b == CODE_USER) || (b == CODE_EXT) ||
                     ((b >= CODE_SLICE_LO) && (b <= CODE_SLICE_HI));
    endfunction

endpackage
`default_nettype wire

// ===== sv/mpeg1_video_picture_framer.sv =====
// MPEG-1 video picture framer: start code detection, frame marking, header capture.
//
// Input channel (s_valid/s_ready): one word per cycle while s_ready is high, s_op = 0 carries a stream
// byte in s_in_byte, s_op = 1 flushes the delay line and restarts the sync hunt.
// Result channel (m_valid/m_ready): one word per kept byte leaving the three-byte
// delay line, with the frame start flag, header change flag, the latest sequence
// header and the latest GOP time code.
// Throughput: one input word per cycle when not stalled. All per-byte work is a
// compare against the start code bytes and a small state update feeding the
// result register. A byte is written to the result register when the third
// following data word is accepted; flush words and dropped bytes give no result.
// Reset (aresetn low, synchronous): delay line empty, start code check armed,
// no header or time code captured, result register empty.
// Stall: s_ready = !m_valid || m_ready, so a full result register that is not
// being taken holds the input side; nothing is lost or repeated.
`default_nettype none
module mpeg1_video_picture_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_frame_start,
    output logic             m_header_changed,
    output logic [11:0]      m_pic_width,
    output logic [11:0]      m_pic_height,
    output logic [3:0]       m_aspect_code,
    output logic [3:0]       m_rate_code,
    output logic             m_timecode_valid,
    output logic [4:0]       m_tc_hours,
    output logic [5:0]       m_tc_minutes,
    output logic [5:0]       m_tc_seconds,
    output logic [5:0]       m_tc_pictures
);

    localparam int unsigned DD = m1vpf_pkg::DELAY_DEPTH;

    logic [7:0]                 dl_byte_reg [DD];
    logic [7:0]                 dl_byte_next [DD];
    logic [DD-1:0]              dl_keep_reg, dl_keep_next;
    logic [1:0]                 zero_run_reg, zero_run_next;
    m1vpf_pkg::sync_mode_t      mode_reg, mode_next;
    logic                       pic_reg, pic_next;
    m1vpf_pkg::capture_kind_t   cap_kind_reg, cap_kind_next;
    logic [2:0]                 cap_count_reg, cap_count_next;
    logic [31:0]                cap_word_reg, cap_word_next;
    logic                       hdr_loaded_reg, hdr_loaded_next;
    logic [31:0]                hdr_reg, hdr_next;
    logic                       chg_reg, chg_next;
    logic                       tc_loaded_reg, tc_loaded_next;
    logic [22:0]                tc_reg, tc_next;

    logic                       m_valid_reg;
    logic                       accept;
    logic                       emit;
    logic                       fs;
    logic                       chg_out;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        logic [7:0]  b;
        logic        code;
        logic        was_sync;
        logic        acquired;
        logic        ok;
        logic        cap_started;
        logic [31:0] w;
        logic [3:0]  asr;
        logic [3:0]  fps;
        logic [31:0] nh;
        logic [2:0]  cnt;

        b           = s_in_byte;
        code        = (zero_run_reg == 2'd3);
        acquired    = 1'b0;
        ok          = 1'b0;
        cap_started = 1'b0;
        fs          = 1'b0;
        emit        = 1'b0;
        w           = '0;
        asr         = '0;
        fps         = '0;
        nh          = '0;
        cnt         = '0;

        dl_byte_next    = dl_byte_reg;
        dl_keep_next    = dl_keep_reg;
        zero_run_next   = zero_run_reg;
        mode_next       = mode_reg;
        pic_next        = pic_reg;
        cap_kind_next   = cap_kind_reg;
        cap_count_next  = cap_count_reg;
        cap_word_next   = cap_word_reg;
        hdr_loaded_next = hdr_loaded_reg;
        hdr_next        = hdr_reg;
        chg_next        = chg_reg;
        tc_loaded_next  = tc_loaded_reg;
        tc_next         = tc_reg;
        chg_out         = chg_reg;
        was_sync        = (mode_reg == m1vpf_pkg::MODE_SYNC);

        if (accept && s_op) begin
            dl_keep_next   = '0;
            zero_run_next  = '0;
            mode_next      = m1vpf_pkg::MODE_HUNT;
            pic_next       = 1'b0;
            cap_kind_next  = m1vpf_pkg::CAP_NONE;
            cap_count_next = '0;
            cap_word_next  = '0;
        end else if (accept) begin
            // zero run tracker: 3 means 00 00 01 was just seen
            if (code) begin
                zero_run_next = (b == 8'h00) ? 2'd1 : 2'd0;
            end else if (b == 8'h00) begin
                zero_run_next = (zero_run_reg >= 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
            end else if (b == 8'h01 && zero_run_reg == 2'd2) begin
                zero_run_next = 2'd3;
            end else begin
                zero_run_next = 2'd0;
            end

            if (mode_reg == m1vpf_pkg::MODE_CHECK) begin
                if (zero_run_reg < 2'd2) begin
                    ok = (b == 8'h00);
                end else if (zero_run_reg == 2'd2) begin
                    ok = (b == 8'h01);
                end else begin
                    ok = m1vpf_pkg::valid_head(b);
                end
                if (!ok) begin
                    mode_next = m1vpf_pkg::MODE_HUNT;
                end else if (code) begin
                    acquired = 1'b1;
                end
            end else if (mode_reg != m1vpf_pkg::MODE_SYNC) begin
                if (code && (b == m1vpf_pkg::CODE_SEQ || b == m1vpf_pkg::CODE_GOP)) begin
                    acquired = 1'b1;
                end
            end

            if (acquired) begin
                dl_keep_next = '1;
                mode_next    = m1vpf_pkg::MODE_SYNC;
                pic_next     = 1'b0;
                fs           = 1'b1;
            end

            if ((was_sync || acquired) && code) begin
                if (b == m1vpf_pkg::CODE_PIC) begin
                    if (pic_next) fs = 1'b1;
                    pic_next = 1'b1;
                end else if (b == m1vpf_pkg::CODE_SEQ || b == m1vpf_pkg::CODE_GOP) begin
                    if (pic_next) fs = 1'b1;
                    pic_next       = 1'b0;
                    cap_kind_next  = (b == m1vpf_pkg::CODE_SEQ) ? m1vpf_pkg::CAP_SEQ
                                                                : m1vpf_pkg::CAP_GOP;
                    cap_count_next = '0;
                    cap_word_next  = '0;
                    cap_started    = 1'b1;
                end else if (b == m1vpf_pkg::CODE_SEQ_END) begin
                    if (pic_next) begin
                        pic_next  = 1'b0;
                        mode_next = m1vpf_pkg::MODE_CHECK;
                    end
                end
            end

            if (!cap_started && cap_kind_reg != m1vpf_pkg::CAP_NONE) begin
                w   = {cap_word_reg[23:0], b};
                cnt = cap_count_reg + 3'd1;
                cap_word_next  = w;
                cap_count_next = cnt;
                if (cnt >= 3'(m1vpf_pkg::CAPTURE_BYTES)) begin
                    if (cap_kind_reg == m1vpf_pkg::CAP_SEQ) begin
                        asr = w[7:4];
                        fps = w[3:0];
                        if (fps < 4'd1 || fps > m1vpf_pkg::RATE_MAX) begin
                            fps = m1vpf_pkg::RATE_DEFAULT;
                        end
                        if (asr < 4'd1 || asr > m1vpf_pkg::ASPECT_MAX) begin
                            asr = m1vpf_pkg::ASPECT_DEFAULT;
                        end
                        nh = {w[31:8], asr, fps};
                        if (!hdr_loaded_reg || nh != hdr_reg) chg_next = 1'b1;
                        hdr_next        = nh;
                        hdr_loaded_next = 1'b1;
                    end else if (cap_kind_reg == m1vpf_pkg::CAP_GOP) begin
                        tc_next        = {w[30:20], w[18:7]};
                        tc_loaded_next = 1'b1;
                    end
                    cap_kind_next  = m1vpf_pkg::CAP_NONE;
                    cap_count_next = '0;
                end
            end

            emit = dl_keep_next[0];
            for (int i = 0; i < DD - 1; i++) begin
                dl_byte_next[i] = dl_byte_reg[i+1];
                dl_keep_next[i] = dl_keep_next[i+1];
            end
            dl_byte_next[DD-1] = b;
            dl_keep_next[DD-1] = was_sync || acquired;

            chg_out = chg_next;
            if (emit) chg_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_keep_reg    <= '0;
            zero_run_reg   <= '0;
            mode_reg       <= m1vpf_pkg::MODE_CHECK;
            pic_reg        <= 1'b0;
            cap_kind_reg   <= m1vpf_pkg::CAP_NONE;
            cap_count_reg  <= '0;
            cap_word_reg   <= '0;
            hdr_loaded_reg <= 1'b0;
            hdr_reg        <= '0;
            chg_reg        <= 1'b0;
            tc_loaded_reg  <= 1'b0;
            tc_reg         <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            dl_keep_reg    <= dl_keep_next;
            zero_run_reg   <= zero_run_next;
            mode_reg       <= mode_next;
            pic_reg        <= pic_next;
            cap_kind_reg   <= cap_kind_next;
            cap_count_reg  <= cap_count_next;
            cap_word_reg   <= cap_word_next;
            hdr_loaded_reg <= hdr_loaded_next;
            hdr_reg        <= hdr_next;
            chg_reg        <= chg_next;
            tc_loaded_reg  <= tc_loaded_next;
            tc_reg         <= tc_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // delay line bytes and result word: payload only
    always_ff @(posedge aclk) begin
        dl_byte_reg <= dl_byte_next;
        if (emit) begin
            m_out_byte       <= dl_byte_reg[0];
            m_frame_start    <= fs;
            m_header_changed <= chg_out;
            m_pic_width      <= hdr_next[31:20];
            m_pic_height     <= hdr_next[19:8];
            m_aspect_code    <= hdr_next[7:4];
            m_rate_code      <= hdr_next[3:0];
            m_timecode_valid <= tc_loaded_next;
            m_tc_hours       <= tc_next[22:18];
            m_tc_minutes     <= tc_next[17:12];
            m_tc_seconds     <= tc_next[11:6];
            m_tc_pictures    <= tc_next[5:0];
        end
    end

endmodule
`default_nettype wire
